// ----- design/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants, job type and character codes for the integer to ASCII
// digit converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 7;

    localparam int VALUE_BITS  = 64;
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 16;
    localparam int DEC_BASE    = 10;

    localparam int STEP_BITS   = 8;
    localparam int NUM_CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS    = NUM_CHUNKS * STEP_BITS;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS + 1);

    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = VALUE_BITS;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int MAX_CHARS   = 64;
    localparam int CHARS_W     = ($clog2(MAX_CHARS + 1) > DIG_CNT_W + 1) ?
                                 $clog2(MAX_CHARS + 1) : DIG_CNT_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic [RADIX_W-1:0]    radix;
    } t_job;

endpackage

// ----- design/i2a_if.sv -----
// ----------------------------------------------------------------------------
// i2a channel interfaces
// Valid/ready channels for the number input and the character output.
// ----------------------------------------------------------------------------
interface i2a_in_if;
    import i2a_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               is_signed;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, value, is_signed, radix, input ready);
    modport sink   (input valid, value, is_signed, radix, output ready);
endinterface

interface i2a_out_if;
    import i2a_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              last;

    modport source (output valid, ascii_char, last, input ready);
    modport sink   (input valid, ascii_char, last, output ready);
endinterface

// ----- design/i2a_front.sv -----
// ----------------------------------------------------------------------------
// i2a_front
// Accepts numbers, clamps the radix, resolves the sign and forms the
// magnitude, and holds the classified job for the queue.
// ----------------------------------------------------------------------------
module i2a_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2a_in_if.sink        i_item,
    output i2a_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import i2a_pkg::*;

    logic                  r_valid;
    t_job                  r_job;
    t_job                  n_job;
    logic [VALUE_BITS-1:0] w_val;

    assign w_val = i_item.value[VALUE_BITS-1:0];

    always_comb begin
        n_job.neg = i_item.is_signed & w_val[VALUE_BITS-1];
        n_job.mag = n_job.neg ? (~w_val + VALUE_BITS'(1)) : w_val;
        if (i_item.radix < RADIX_W'(RADIX_MIN)) begin
            n_job.radix = RADIX_W'(RADIX_MIN);
        end else if (i_item.radix > RADIX_W'(RADIX_MAX)) begin
            n_job.radix = RADIX_W'(RADIX_MAX);
        end else begin
            n_job.radix = i_item.radix;
        end
    end

    assign i_item.ready = !r_valid || i_job_ready;
    assign o_job        = r_job;
    assign o_job_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_valid <= 1'b1;
                r_job   <= n_job;
            end else if (i_job_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/i2a_queue.sv -----
// ----------------------------------------------------------------------------
// i2a_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module i2a_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  i2a_pkg::t_job i_push_job,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output i2a_pkg::t_job o_pop_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);
    import i2a_pkg::*;

    t_job              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_entries[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_entries[r_wptr] <= i_push_job;
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/i2a_back.sv -----
// ----------------------------------------------------------------------------
// i2a_back
// Divides the magnitude by the radix one digit at a time, eight quotient
// bits per cycle, stacks the remainders and sends them out as characters,
// most significant first, after a leading '-' for a negative value.
// ----------------------------------------------------------------------------
module i2a_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  i2a_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    i2a_out_if.source     o_char
);
    import i2a_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_PUT
    } t_state;

    t_state                 r_state;
    logic [PAD_BITS-1:0]    r_mag;
    logic                   r_neg;
    logic [RADIX_W-1:0]     r_radix;
    logic [CHUNK_CNT_W-1:0] r_nbytes;
    logic [CHUNK_IDX_W-1:0] r_idx;
    logic [DIGIT_W-1:0]     r_rem;
    logic                   r_qnz;
    logic [DIG_CNT_W-1:0]   r_nd;
    logic [DIG_IDX_W-1:0]   r_rd_idx;
    logic [DIG_CNT_W-1:0]   r_stop;
    logic [DIGIT_W-1:0]     r_digits [MAX_DIGITS];
    logic [DIGIT_W-1:0]     r_rd_data;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;

    logic [STEP_BITS-1:0]   w_chunk;
    logic [STEP_BITS-1:0]   w_quo;
    logic [DIGIT_W:0]       w_trial;
    logic [DIGIT_W-1:0]     n_rem;
    logic [PAD_BITS-1:0]    n_mag;
    logic [CHUNK_CNT_W-1:0] n_nbytes;
    logic                   n_qnz;
    logic [DIG_CNT_W-1:0]   n_nd;
    logic [CHARS_W-1:0]     w_chars;
    logic [DIG_CNT_W-1:0]   n_stop;
    logic                   w_top;
    logic                   w_we;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_is_last;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(DEC_BASE)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_W'(DEC_BASE));
        end
        return c;
    endfunction

    always_comb begin
        w_chunk = r_mag[r_idx*STEP_BITS +: STEP_BITS];
        n_rem   = r_rem;
        w_trial = '0;
        w_quo   = '0;
        for (int b = STEP_BITS - 1; b >= 0; b--) begin
            w_trial = {n_rem, w_chunk[b]};
            if (w_trial >= r_radix) begin
                w_trial  = w_trial - r_radix;
                w_quo[b] = 1'b1;
            end
            n_rem = w_trial[DIGIT_W-1:0];
        end
        n_mag = r_mag;
        n_mag[r_idx*STEP_BITS +: STEP_BITS] = w_quo;
    end

    assign w_top    = (CHUNK_CNT_W'(r_idx) == r_nbytes - CHUNK_CNT_W'(1));
    assign n_nbytes = (w_top && (w_quo == '0) && (r_nbytes > CHUNK_CNT_W'(1))) ?
                      r_nbytes - CHUNK_CNT_W'(1) : r_nbytes;
    assign n_qnz    = r_qnz | (|w_quo);
    assign n_nd     = r_nd + DIG_CNT_W'(1);
    assign w_chars  = CHARS_W'(n_nd) + CHARS_W'(r_neg);
    assign n_stop   = (w_chars > CHARS_W'(MAX_CHARS)) ?
                      DIG_CNT_W'(w_chars - CHARS_W'(MAX_CHARS)) : '0;
    assign w_we     = (r_state == S_DIV) && (r_idx == '0);

    assign w_out_free  = !r_out_valid || o_char.ready;
    assign w_out_load  = w_out_free && ((r_state == S_SIGN) || (r_state == S_PUT));
    assign w_is_last   = (DIG_CNT_W'(r_rd_idx) == r_stop);
    assign o_job_ready = (r_state == S_IDLE);

    assign o_char.valid      = r_out_valid;
    assign o_char.ascii_char = r_out_char;
    assign o_char.last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_digits[r_nd[DIG_IDX_W-1:0]] <= n_rem;
        end
        r_rd_data <= r_digits[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_nd        <= '0;
        end else begin
            if (o_char.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_mag    <= PAD_BITS'(i_job.mag);
                        r_neg    <= i_job.neg;
                        r_radix  <= i_job.radix;
                        r_nbytes <= CHUNK_CNT_W'(NUM_CHUNKS);
                        r_idx    <= CHUNK_IDX_W'(NUM_CHUNKS - 1);
                        r_rem    <= '0;
                        r_qnz    <= 1'b0;
                        r_nd     <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_mag    <= n_mag;
                    r_nbytes <= n_nbytes;
                    if (r_idx == '0) begin
                        r_nd <= n_nd;
                        if (n_qnz && (n_nd < DIG_CNT_W'(MAX_DIGITS))) begin
                            r_idx <= CHUNK_IDX_W'(n_nbytes - CHUNK_CNT_W'(1));
                            r_rem <= '0;
                            r_qnz <= 1'b0;
                        end else begin
                            r_rd_idx <= r_nd[DIG_IDX_W-1:0];
                            r_stop   <= n_stop;
                            r_state  <= r_neg ? S_SIGN : S_READ;
                        end
                    end else begin
                        r_idx <= r_idx - CHUNK_IDX_W'(1);
                        r_rem <= n_rem;
                        r_qnz <= n_qnz;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= digit_char(r_rd_data);
                        r_out_last  <= w_is_last;
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_idx <= r_rd_idx - DIG_IDX_W'(1);
                            r_state  <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (CHUNK_CNT_W'(r_idx) < r_nbytes) && (RADIX_W'(r_rem) < r_radix))
        else $error("divide step outside active chunks or remainder not below radix");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= DIG_CNT_W'(MAX_DIGITS))
        else $error("digit count beyond stack depth");

    a_read_above_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (DIG_CNT_W'(r_rd_idx) >= r_stop))
        else $error("digit read past the stop index");

    a_digit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (RADIX_W'(r_rd_data) < r_radix))
        else $error("stacked digit not below radix");

endmodule

// ----- design/integer_to_ascii_digits_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_unit
// Converts a number into ASCII digits in radix 2 to 16.
// ----------------------------------------------------------------------------
// Each number produces its characters most significant first, a leading '-'
// for a negative signed value, with last set on the final one; output is
// capped at 64 characters. Throughput is set by the single shared divide
// unit: each digit divides the remaining quotient 8 bits at a time, so
// it gets faster as the value shrinks, and then every character passes
// through the registered digit stack. The front stage and a two-entry
// queue accept up to three further numbers while one is being converted.
// No pass is needed after reset.
module integer_to_ascii_digits_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2a_in_if.sink    i_item,
    i2a_out_if.source o_char
);
    import i2a_pkg::*;

    t_job w_front_job;
    logic w_front_valid;
    logic w_front_ready;
    t_job w_back_job;
    logic w_back_valid;
    logic w_back_ready;

    i2a_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_job       (w_front_job),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready)
    );

    i2a_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_job   (w_front_job),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .o_pop_job    (w_back_job),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready)
    );

    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_back_job),
        .i_job_valid (w_back_valid),
        .o_job_ready (w_back_ready),
        .o_char      (o_char)
    );

endmodule
